// ----- rtl/clnws_pkg.sv -----
// Shared types and constants for the character LCD nibble write sequencer.
// Used by clnws_ctrl, clnws_dp and the top level; no dependencies.
package clnws_pkg;

    localparam int unsigned WAIT_W = 16;
    localparam int unsigned STEP_W = 3;

    // operation codes of an input word
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_CHAR    = 2'd1;
    localparam logic [1:0] OP_MOVE    = 2'd2;

    localparam logic [1:0] ROW_ONE = 2'd1;
    localparam logic [1:0] ROW_TWO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_COMMAND_WAIT = 2'd0;
    localparam logic [1:0] CFG_CHAR_WAIT    = 2'd1;

    localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd80;

    // pin-state steps, numbered as in the character sequence;
    // a command skips STEP_LO_SETUP
    localparam logic [STEP_W-1:0] STEP_HELD     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_HI_EN    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_HI_HOLD  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LO_SETUP = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LO_EN    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST     = 3'd5;

    typedef struct packed {
        logic              capture;
        logic              load;
        logic              is_char;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

endpackage

// ----- rtl/clnws_ctrl.sv -----
// Controller of the LCD nibble write sequencer: input handshake, step sequencing
// and the valid flag of the output register. Depends on clnws_pkg.
module clnws_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [1:0]         i_row,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output clnws_pkg::t_dp_cmd o_cmd
);
    import clnws_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_is_char;
    logic              r_out_valid;

    logic              w_accept;
    logic              w_start;
    logic              w_free;
    logic              w_load;
    logic [STEP_W-1:0] w_next_step;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_start     = (i_op == OP_COMMAND) || (i_op == OP_CHAR) ||
                         ((i_op == OP_MOVE) && ((i_row == ROW_ONE) || (i_row == ROW_TWO)));
    assign w_free      = !r_out_valid || i_out_ready;
    assign w_load      = (r_state == S_RUN) && w_free;
    // a command has no separate low-nibble setup state
    assign w_next_step = ((r_step == STEP_HI_HOLD) && !r_is_char) ? STEP_LO_EN
                                                                  : r_step + 3'd1;

    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = w_accept;
    assign o_cmd.load    = w_load;
    assign o_cmd.is_char = r_is_char;
    assign o_cmd.step    = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_HELD;
            r_is_char   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_start) begin
                        r_state   <= S_RUN;
                        r_step    <= STEP_HELD;
                        r_is_char <= (i_op == OP_CHAR);
                    end
                end
                S_RUN: begin
                    if (w_load) begin
                        if (r_step == STEP_LAST) begin
                            r_state <= S_IDLE;
                            r_step  <= STEP_HELD;
                        end else begin
                            r_step <= w_next_step;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_step  <= STEP_HELD;
                end
            endcase
        end
    end

    a_cmd_skips_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !r_is_char) |-> (r_step != STEP_LO_SETUP))
        else $error("command sequence reached the character-only setup step");

    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_step == STEP_HELD))
        else $error("step counter not cleared while idle");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_step == STEP_LAST) |=> (r_state == S_IDLE && r_out_valid))
        else $error("final pin state did not return controller to idle");

    a_valid_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RUN))
        else $error("output word appeared without a running sequence");

endmodule

// ----- rtl/clnws_dp.sv -----
// Datapath of the LCD nibble write sequencer: wait registers, captured byte,
// held nibble and the output register. Depends on clnws_pkg.
module clnws_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  clnws_pkg::t_dp_cmd              i_cmd,
    input  logic                            i_cfg_valid,
    input  logic [1:0]                      i_cfg_index,
    input  logic [clnws_pkg::WAIT_W-1:0]    i_cfg_data,
    input  logic [1:0]                      i_op,
    input  logic [7:0]                      i_value,
    input  logic [1:0]                      i_row,
    input  logic [5:0]                      i_column,
    output logic [3:0]                      o_data_nibble,
    output logic                            o_register_select,
    output logic                            o_enable,
    output logic [clnws_pkg::WAIT_W-1:0]    o_wait_us,
    output logic                            o_last
);
    import clnws_pkg::*;

    logic [WAIT_W-1:0] r_command_wait;
    logic [WAIT_W-1:0] r_char_wait;
    logic [3:0]        r_held_nibble;
    logic [7:0]        r_byte;
    logic [3:0]        r_nibble;
    logic              r_rs;
    logic              r_en;
    logic [WAIT_W-1:0] r_wait;
    logic              r_last;

    logic [7:0]        n_byte;
    logic [3:0]        n_nibble;
    logic              n_en;

    // row base 0x80 or 0xC0 plus a 6-bit column never carries
    assign n_byte = (i_op == OP_MOVE) ? {1'b1, (i_row == ROW_TWO), i_column} : i_value;

    always_comb begin
        n_nibble = r_byte[3:0];
        n_en     = 1'b0;
        case (i_cmd.step)
            STEP_HELD:     n_nibble = r_held_nibble;
            STEP_HI_EN:    begin n_nibble = r_byte[7:4]; n_en = 1'b1; end
            STEP_HI_HOLD:  n_nibble = r_byte[7:4];
            STEP_LO_SETUP: n_nibble = r_byte[3:0];
            STEP_LO_EN:    begin n_nibble = r_byte[3:0]; n_en = 1'b1; end
            STEP_LAST:     n_nibble = r_byte[3:0];
            default:       n_nibble = r_byte[3:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_wait <= WAIT_RESET;
            r_char_wait    <= WAIT_RESET;
            r_held_nibble  <= 4'd0;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_COMMAND_WAIT) begin
                r_command_wait <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_CHAR_WAIT) begin
                r_char_wait <= i_cfg_data;
            end
            // pins rest on the low nibble once the byte is out
            if (i_cmd.load && i_cmd.step == STEP_LAST) begin
                r_held_nibble <= r_byte[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= n_byte;
        end
        if (i_cmd.load) begin
            r_nibble <= n_nibble;
            r_rs     <= i_cmd.is_char;
            r_en     <= n_en;
            r_wait   <= i_cmd.is_char ? r_char_wait : r_command_wait;
            r_last   <= (i_cmd.step == STEP_LAST);
        end
    end

    assign o_data_nibble     = r_nibble;
    assign o_register_select = r_rs;
    assign o_enable          = r_en;
    assign o_wait_us         = r_wait;
    assign o_last            = r_last;

endmodule

// ----- rtl/char_lcd_nibble_write_sequencer.sv -----
// Top level of the character LCD nibble write sequencer.
// Instantiates clnws_ctrl and clnws_dp; depends on clnws_pkg.
//
// Turns each input word (command byte, character byte or cursor move) into the
// pin states of a 4-bit HD44780-style write: five for a command, six for a
// character, high nibble first, each tagged with its hold time in microseconds
// taken from the command or character wait register. A cursor move to row 1 or
// 2 is sent as command 0x80 or 0xC0 plus the column; other rows and operation 3
// produce nothing. One pin state leaves per cycle while the output is taken, so
// a word occupies the sequencer from its acceptance until its last pin state
// is loaded; the step counter of the controller walks it through its steps.
// The next word is accepted while the last pin state still waits in the output
// register. Hold times are reported, not spent. Configuration writes are taken
// in any cycle and must only be issued while the block is idle.
module char_lcd_nibble_write_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] value, [9:8] row, [15:10] column
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // pin-state words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] data_nibble, [4] enable, [20:5] wait_us, pad
    output logic        m_axis_tuser,   // [0] register_select
    output logic        m_axis_tlast
);
    import clnws_pkg::*;

    t_dp_cmd           w_cmd;
    logic [3:0]        w_nibble;
    logic              w_enable;
    logic [WAIT_W-1:0] w_wait;

    assign o_cfg_ready = 1'b1;

    clnws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_row       (s_axis_tdata[9:8]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    clnws_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (s_axis_tuser),
        .i_value           (s_axis_tdata[7:0]),
        .i_row             (s_axis_tdata[9:8]),
        .i_column          (s_axis_tdata[15:10]),
        .o_data_nibble     (w_nibble),
        .o_register_select (m_axis_tuser),
        .o_enable          (w_enable),
        .o_wait_us         (w_wait),
        .o_last            (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_wait, w_enable, w_nibble};

endmodule

// ----- test/clnws_checker.sv -----
`timescale 1ns / 1ps
// Checker for the character LCD nibble write sequencer: watches the config, input and
// pin-state channels, predicts each pin-state word and compares it field by field.
// Depends on clnws_pkg; instantiated beside the block by tb.
module clnws_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,      // [7:0] value, [9:8] row, [15:10] column
    input  logic [1:0]  i_in_op,        // [1:0] operation
    input  logic        i_pin_valid,
    input  logic        i_pin_ready,
    input  logic [23:0] i_pin_data,     // [3:0] data_nibble, [4] enable, [20:5] wait_us
    input  logic        i_pin_rs,       // [0] register_select
    input  logic        i_pin_last,
    output int          o_errors,
    output int          o_pending
);
    import clnws_pkg::*;

    localparam logic [7:0] ROW_ONE_BASE = 8'h80;
    localparam logic [7:0] ROW_TWO_BASE = 8'hC0;

    typedef struct packed {
        logic [3:0]        nibble;
        logic              rs;
        logic              en;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } t_pin_state;

    t_pin_state        pins_due[$];
    logic [WAIT_W-1:0] command_wait = WAIT_RESET;
    logic [WAIT_W-1:0] char_wait    = WAIT_RESET;
    logic [3:0]        held_nibble  = 4'd0;
    int                errors       = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("clnws_checker: %0t ns %s got 0x%0h want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    function automatic t_pin_state pin(input logic [3:0] nib, input logic rs, input logic en,
                                       input logic [WAIT_W-1:0] w, input logic last);
        t_pin_state p;
        p.nibble  = nib;
        p.rs      = rs;
        p.en      = en;
        p.wait_us = w;
        p.last    = last;
        return p;
    endfunction

    // queue the strobe sequence of one byte, high nibble first
    task automatic queue_byte(input logic [7:0] b, input logic is_char);
        logic [WAIT_W-1:0] w;
        w = is_char ? char_wait : command_wait;
        pins_due.push_back(pin(held_nibble, is_char, 1'b0, w, 1'b0));
        pins_due.push_back(pin(b[7:4], is_char, 1'b1, w, 1'b0));
        pins_due.push_back(pin(b[7:4], is_char, 1'b0, w, 1'b0));
        if (is_char) begin
            pins_due.push_back(pin(b[3:0], is_char, 1'b0, w, 1'b0));
        end
        pins_due.push_back(pin(b[3:0], is_char, 1'b1, w, 1'b0));
        pins_due.push_back(pin(b[3:0], is_char, 1'b0, w, 1'b1));
        held_nibble = b[3:0];
    endtask

    always @(posedge i_clk) begin
        t_pin_state want;
        logic [7:0] value;
        logic [1:0] row;
        logic [5:0] column;
        value  = i_in_data[7:0];
        row    = i_in_data[9:8];
        column = i_in_data[15:10];
        if (!i_rst_n) begin
            pins_due.delete();
            command_wait = WAIT_RESET;
            char_wait    = WAIT_RESET;
            held_nibble  = 4'd0;
        end else begin
            // compare before queueing: a word accepted on this edge cannot answer yet
            if (i_pin_valid && i_pin_ready) begin
                if (pins_due.size() == 0) begin
                    report("unexpected pin-state word", 32'(i_pin_data), 32'd0);
                end else begin
                    want = pins_due.pop_front();
                    if (i_pin_data[3:0] != want.nibble)
                        report("data_nibble", 32'(i_pin_data[3:0]), 32'(want.nibble));
                    if (i_pin_rs != want.rs)
                        report("register_select", 32'(i_pin_rs), 32'(want.rs));
                    if (i_pin_data[4] != want.en)
                        report("enable", 32'(i_pin_data[4]), 32'(want.en));
                    if (i_pin_data[20:5] != want.wait_us)
                        report("wait_us", 32'(i_pin_data[20:5]), 32'(want.wait_us));
                    if (i_pin_last != want.last)
                        report("last", 32'(i_pin_last), 32'(want.last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COMMAND_WAIT: command_wait = i_cfg_data;
                    CFG_CHAR_WAIT:    char_wait    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_op)
                    OP_COMMAND: queue_byte(value, 1'b0);
                    OP_CHAR:    queue_byte(value, 1'b1);
                    OP_MOVE: begin
                        if (row == ROW_ONE)
                            queue_byte(ROW_ONE_BASE + {2'b00, column}, 1'b0);
                        else if (row == ROW_TWO)
                            queue_byte(ROW_TWO_BASE + {2'b00, column}, 1'b0);
                    end
                    default: ;
                endcase
            end
        end
        o_pending = pins_due.size();
        o_errors  = errors;
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for char_lcd_nibble_write_sequencer: clock, reset, stimulus and verdict.
// Depends on clnws_pkg, the block and clnws_checker.
module tb;
    import clnws_pkg::*;

    localparam logic [1:0] OP_NONE   = 2'd3;
    localparam logic [1:0] ROW_ZERO  = 2'd0;
    localparam logic [1:0] ROW_THREE = 2'd3;
    localparam int RANDOM_PER_PHASE  = 84;
    localparam int SETTLE_CYCLES     = 10;
    localparam int STALL_LIMIT       = 1000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_COMMAND_WAIT;
    logic [15:0] i_cfg_data    = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = 16'd0;
    logic [1:0]  s_axis_tuser  = OP_COMMAND;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    char_lcd_nibble_write_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    clnws_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_op     (s_axis_tuser),
        .i_pin_valid (m_axis_tvalid),
        .i_pin_ready (m_axis_tready),
        .i_pin_data  (m_axis_tdata),
        .i_pin_rs    (m_axis_tuser),
        .i_pin_last  (m_axis_tlast),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // abort when no word moves on any channel for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [7:0] value,
                             input logic [1:0] row, input logic [5:0] column);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {column, row, value};
        s_axis_tuser  = op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [1:0] op;
        op = ($urandom_range(19) == 0) ? OP_NONE : 2'($urandom_range(2));
        send_word(op, 8'($urandom), 2'($urandom), 6'($urandom));
    endtask

    // hold the input until every pin state has left, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct,
                             input logic [15:0] cmd_wait, input logic [15:0] chr_wait);
        drain();
        write_reg(CFG_COMMAND_WAIT, cmd_wait);
        write_reg(CFG_CHAR_WAIT, chr_wait);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_random();
            // pause the sender once mid-phase until the output runs dry
            if (n == RANDOM_PER_PHASE / 2) drain();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words under the reset hold times
        send_idle_pct = 9;
        recv_idle_pct = 69;
        send_word(OP_COMMAND, 8'h00, ROW_ZERO, 6'h00);
        send_word(OP_COMMAND, 8'hFF, ROW_THREE, 6'h3F);
        send_word(OP_CHAR, 8'h00, ROW_ONE, 6'h2A);
        send_word(OP_CHAR, 8'hFF, ROW_TWO, 6'h15);
        send_word(OP_CHAR, 8'hA5, ROW_ZERO, 6'h3F);
        send_word(OP_COMMAND, 8'h5A, ROW_ONE, 6'h00);
        send_word(OP_MOVE, 8'hFF, ROW_ONE, 6'h00);
        send_word(OP_MOVE, 8'h00, ROW_ONE, 6'h3F);
        send_word(OP_MOVE, 8'hFF, ROW_TWO, 6'h00);
        send_word(OP_MOVE, 8'h00, ROW_TWO, 6'h3F);
        // moves to rows without a base address and the spare opcode leave the pins alone
        send_word(OP_MOVE, 8'h3C, ROW_ZERO, 6'h15);
        send_word(OP_MOVE, 8'hC3, ROW_THREE, 6'h2A);
        send_word(OP_NONE, 8'h3C, ROW_ONE, 6'h3F);
        send_word(OP_CHAR, 8'h3C, ROW_TWO, 6'h00);
        send_word(OP_COMMAND, 8'h01, ROW_ONE, 6'h01);
        send_word(OP_CHAR, 8'h96, ROW_THREE, 6'h3F);

        run_phase(9, 69, 16'd0, 16'hFFFF);
        run_phase(69, 9, 16'hFFFF, 16'd0);
        run_phase(0, 0, 16'($urandom), 16'($urandom));

        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- char_lcd_nibble_write_sequencer.f -----
rtl/clnws_pkg.sv
rtl/clnws_ctrl.sv
rtl/clnws_dp.sv
rtl/char_lcd_nibble_write_sequencer.sv
test/clnws_checker.sv
test/tb.sv
